@@ rtl/dlht_pkg.sv @@
// shared constants, codes and types of the d-left hash table
// no dependencies; used by d_left_hash_table and dlht_checker
package dlht_pkg;

    localparam int TABLES_DEF      = 4;
    localparam int SLOT_BITS_DEF   = 10;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FP_W     = 32;
    localparam int IDX_W    = 10;
    localparam int IDX_NUM  = 4;
    localparam int EVAL_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int RVAL_W   = 32;
    localparam int HTAB_W   = 2;
    localparam int HSLOT_W  = 10;
    localparam int TACT_W   = 3;

    localparam int FP_LSB   = 0;
    localparam int IDX_LSB  = FP_W;
    localparam int EVAL_LSB = IDX_LSB + IDX_NUM * IDX_W;
    localparam int S_DATA_BITS = EVAL_LSB + EVAL_W;
    localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = RVAL_W + HTAB_W + HSLOT_W + TACT_W;
    localparam int M_TDATA_W   = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W   = CMD_W;
    localparam int M_TUSER_W   = STATUS_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_NEW         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_HIT         = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_MISS        = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_REMOVED     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_REMOVE_MISS = 3'd6;
    localparam logic [STATUS_W-1:0] STAT_CLEARED     = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TACT_W-1:0]   tables_active;
        logic [HSLOT_W-1:0]  hit_slot;
        logic [HTAB_W-1:0]   hit_table;
        logic [RVAL_W-1:0]   read_value;
    } result_t;

endpackage

@@ rtl/d_left_hash_table.sv @@
// d-left hash table: banked fingerprint and value memories, one bank per subtable
// depends on dlht_pkg
//
// usage:
//   slave channel s_*: one command per beat; s_tuser carries the command code,
//   s_tdata the fingerprint, the four slot indexes and the value to insert.
//   master channel m_*: one result per command; m_tuser carries the status,
//   m_tdata the read value, subtable, slot and number of active subtables.
//   insert, lookup and remove read all banks in parallel at the accepting edge,
//   then decide and write back in the probe state; the result is registered
//   into the output register, or into the holding register while the output
//   is stalled, and the next command is taken once the block is idle again.
//   clear sweeps every bank one slot per cycle. after reset the block runs
//   the same sweep with s_tready low, then starts with one active subtable.
//   a stalled result is held in the output register; one more finished result
//   waits in a holding register, after which the block stops taking commands.
module d_left_hash_table #(
    parameter int TABLES      = dlht_pkg::TABLES_DEF,
    parameter int SLOT_BITS   = dlht_pkg::SLOT_BITS_DEF,
    parameter int VALUE_WIDTH = dlht_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fingerprint, index_0, index_1, index_2, index_3, entry_value
    input  logic [dlht_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [dlht_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value, hit_table, hit_slot, tables_active, zero pad
    output logic [dlht_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [dlht_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int SLOTS = 1 << SLOT_BITS;
    localparam int TBITS = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int CBITS = $clog2(TABLES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [CBITS-1:0]              active_reg, active_next, active_calc;
    logic [SLOT_BITS-1:0]          sweep_cnt_reg, sweep_cnt_next;
    logic                          sweep_init_reg, sweep_init_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          load_out, load_pend;

    logic [dlht_pkg::CMD_W-1:0]    cmd_reg;
    logic [dlht_pkg::FP_W-1:0]     fp_reg;
    logic [VALUE_WIDTH-1:0]        val_reg;
    logic [SLOT_BITS-1:0]          slot_reg [TABLES];
    logic [dlht_pkg::FP_W-1:0]     rd_fp_reg [TABLES];
    logic [VALUE_WIDTH-1:0]        rd_val_reg [TABLES];
    dlht_pkg::result_t             out_reg, pend_reg, res_probe, res_load;

    logic                          accept, out_free, sweep_last;
    logic [SLOT_BITS-1:0]          rd_addr [TABLES];
    logic [TABLES-1:0]             fp_we, val_we;
    logic [SLOT_BITS-1:0]          wr_addr [TABLES];
    logic [dlht_pkg::FP_W-1:0]     fp_wdata;
    logic                          wr_fp_en, wr_val_en;
    logic [TBITS-1:0]              wr_bank;
    logic                          found, found_free;
    logic [TBITS-1:0]              sel;

    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || m_tready;
    assign sweep_last = (sweep_cnt_reg == SLOT_BITS'(SLOTS - 1));

    // banks
    for (genvar b = 0; b < TABLES; b++) begin : g_bank
        logic [dlht_pkg::FP_W-1:0] fp_mem  [SLOTS];
        logic [VALUE_WIDTH-1:0]    val_mem [SLOTS];

        assign rd_addr[b] = SLOT_BITS'(s_tdata[dlht_pkg::IDX_LSB
                            + (b % dlht_pkg::IDX_NUM) * dlht_pkg::IDX_W +: dlht_pkg::IDX_W]);
        assign wr_addr[b] = (state_reg == ST_SWEEP) ? sweep_cnt_reg : slot_reg[b];
        assign fp_we[b]   = (state_reg == ST_SWEEP)
                         || ((state_reg == ST_PROBE) && wr_fp_en && (wr_bank == TBITS'(b)));
        assign val_we[b]  = (state_reg == ST_PROBE) && wr_val_en && (wr_bank == TBITS'(b));

        always_ff @(posedge clk)
        begin
            if (fp_we[b])
            begin
                fp_mem[wr_addr[b]] <= fp_wdata;
            end
            if (val_we[b])
            begin
                val_mem[wr_addr[b]] <= val_reg;
            end
            if (accept)
            begin
                rd_fp_reg[b]  <= fp_mem[rd_addr[b]];
                rd_val_reg[b] <= val_mem[rd_addr[b]];
                slot_reg[b]   <= rd_addr[b];
            end
        end
    end

    // first qualifying active subtable
    always_comb
    begin
        found      = 1'b0;
        found_free = 1'b0;
        sel        = '0;
        for (int t = 0; t < TABLES; t++)
        begin
            if (!found && (CBITS'(t) < active_reg)
                && ((rd_fp_reg[t] == fp_reg)
                    || ((cmd_reg == dlht_pkg::CMD_INSERT) && (rd_fp_reg[t] == '0))))
            begin
                found      = 1'b1;
                found_free = (rd_fp_reg[t] == '0);
                sel        = TBITS'(t);
            end
        end
    end

    // decision and write-back
    always_comb
    begin
        res_probe               = '0;
        active_calc             = active_reg;
        wr_fp_en                = 1'b0;
        wr_val_en               = 1'b0;
        wr_bank                 = sel;
        fp_wdata                = (state_reg == ST_SWEEP) ? '0 : fp_reg;
        case (cmd_reg)
            dlht_pkg::CMD_INSERT:
            begin
                if (fp_reg == '0)
                begin
                    res_probe.status = dlht_pkg::STAT_FULL;
                end
                else if (found)
                begin
                    wr_fp_en            = 1'b1;
                    wr_val_en           = 1'b1;
                    res_probe.status    = found_free ? dlht_pkg::STAT_NEW
                                                     : dlht_pkg::STAT_UPDATED;
                    res_probe.hit_table = dlht_pkg::HTAB_W'(sel);
                    res_probe.hit_slot  = dlht_pkg::HSLOT_W'(slot_reg[sel]);
                end
                else if (active_reg < CBITS'(TABLES))
                begin
                    wr_bank             = TBITS'(active_reg);
                    wr_fp_en            = 1'b1;
                    wr_val_en           = 1'b1;
                    active_calc         = active_reg + 1'b1;
                    res_probe.status    = dlht_pkg::STAT_NEW;
                    res_probe.hit_table = dlht_pkg::HTAB_W'(active_reg);
                    res_probe.hit_slot  = dlht_pkg::HSLOT_W'(slot_reg[TBITS'(active_reg)]);
                end
                else
                begin
                    res_probe.status = dlht_pkg::STAT_FULL;
                end
            end
            dlht_pkg::CMD_LOOKUP:
            begin
                if (found && (fp_reg != '0))
                begin
                    res_probe.status     = dlht_pkg::STAT_HIT;
                    res_probe.read_value = dlht_pkg::RVAL_W'(rd_val_reg[sel]);
                    res_probe.hit_table  = dlht_pkg::HTAB_W'(sel);
                    res_probe.hit_slot   = dlht_pkg::HSLOT_W'(slot_reg[sel]);
                end
                else
                begin
                    res_probe.status = dlht_pkg::STAT_MISS;
                end
            end
            dlht_pkg::CMD_REMOVE:
            begin
                if (found && (fp_reg != '0))
                begin
                    wr_fp_en            = 1'b1;
                    fp_wdata            = '0;
                    res_probe.status    = dlht_pkg::STAT_REMOVED;
                    res_probe.hit_table = dlht_pkg::HTAB_W'(sel);
                    res_probe.hit_slot  = dlht_pkg::HSLOT_W'(slot_reg[sel]);
                end
                else
                begin
                    res_probe.status = dlht_pkg::STAT_REMOVE_MISS;
                end
            end
            default:
            begin
                res_probe.status = dlht_pkg::STAT_CLEARED;
            end
        endcase
        res_probe.tables_active = dlht_pkg::TACT_W'(active_calc);
    end

    // control
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_init_next = sweep_init_reg;
        load_out        = 1'b0;
        load_pend       = 1'b0;
        res_load        = res_probe;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sweep_cnt_next = '0;
                    state_next     = (s_tuser == dlht_pkg::CMD_CLEAR) ? ST_SWEEP : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                active_next = active_calc;
                load_out    = out_free;
                load_pend   = !out_free;
                state_next  = out_free ? ST_IDLE : ST_EMIT;
            end
            ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    sweep_init_next = 1'b0;
                    if (sweep_init_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        load_out   = out_free;
                        load_pend  = !out_free;
                        state_next = out_free ? ST_IDLE : ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                res_load   = pend_reg;
                load_out   = out_free;
                state_next = out_free ? ST_IDLE : ST_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            active_reg     <= CBITS'(1);
            sweep_cnt_reg  <= '0;
            sweep_init_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_init_reg <= sweep_init_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            fp_reg  <= s_tdata[dlht_pkg::FP_LSB +: dlht_pkg::FP_W];
            val_reg <= VALUE_WIDTH'(s_tdata[dlht_pkg::EVAL_LSB +: dlht_pkg::EVAL_W]);
        end
        if (load_out)
        begin
            out_reg <= res_load;
        end
        if (load_pend)
        begin
            pend_reg <= res_probe;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = dlht_pkg::M_TDATA_W'({out_reg.tables_active, out_reg.hit_slot,
                                            out_reg.hit_table, out_reg.read_value});

endmodule

@@ rtl/dlht_checker.sv @@
// port-level checks of the d-left hash table, bound to its top level
// depends on dlht_pkg and d_left_hash_table
module dlht_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [dlht_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [dlht_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dlht_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [dlht_pkg::M_TUSER_W-1:0] m_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while previous still in work");

    // empty results carry no location
    a_empty_loc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dlht_pkg::STAT_MISS || m_tuser == dlht_pkg::STAT_FULL
            || m_tuser == dlht_pkg::STAT_REMOVE_MISS || m_tuser == dlht_pkg::STAT_CLEARED)
        |-> m_tdata[dlht_pkg::RVAL_W + dlht_pkg::HTAB_W + dlht_pkg::HSLOT_W - 1:0] == '0)
        else $error("location reported on empty result");

    // only a hit returns a value
    a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != dlht_pkg::STAT_HIT) |-> m_tdata[dlht_pkg::RVAL_W-1:0] == '0)
        else $error("value returned without hit");

    // reset runs the clearing sweep with both channels quiet
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !s_tready && !m_tvalid)
        else $error("channel active during reset");

endmodule

bind d_left_hash_table dlht_checker u_dlht_checker (.*);

@@ test/tb_top.sv @@
// testbench of the d-left hash table: directed and random insert, lookup, remove and clear
// beats against a cycle-free prediction of the subtables; depends on dlht_pkg and
// d_left_hash_table
`timescale 1ns / 1ps

module tb_top;
    import dlht_pkg::*;

    localparam int NSLOT = 1 << SLOT_BITS_DEF;
    localparam int NPOOL = 32;

    typedef struct packed {
        bit                         pause;
        logic [EVAL_W-1:0]          value;
        logic [IDX_NUM-1:0][IDX_W-1:0] idx;
        logic [FP_W-1:0]            fp;
        logic [CMD_W-1:0]           cmd;
    } cmd_item_t;

    logic clk;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    d_left_hash_table uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicted table contents
    logic [FP_W-1:0]   fp_mem  [TABLES_DEF][NSLOT];
    logic [EVAL_W-1:0] val_mem [TABLES_DEF][NSLOT];
    int                n_active;

    cmd_item_t cmd_q[$];
    result_t   result_q[$];
    cmd_item_t cur_item;
    result_t   want;
    int        accepted_cnt = 0;
    int        total_items;
    int        fail_cnt = 0;
    logic      calm;

    logic [FP_W-1:0]               pool_fp  [NPOOL];
    logic [IDX_NUM-1:0][IDX_W-1:0] pool_idx [NPOOL];

    assign calm = accepted_cnt >= 150 && accepted_cnt < 300;

    function automatic result_t run_table_op(cmd_item_t it);
        result_t          r;
        logic [IDX_W-1:0] s;
        int               t;
        bit               done;
        r = '0;
        done = 0;
        if (it.cmd == CMD_CLEAR)
        begin
            for (t = 0; t < n_active; t++)
                for (int k = 0; k < NSLOT; k++)
                    fp_mem[t][k] = '0;
            r.status = STAT_CLEARED;
        end
        else if (it.cmd == CMD_INSERT)
        begin
            r.status = STAT_FULL;
            if (it.fp != '0)
            begin
                for (t = 0; t < n_active && !done; t++)
                begin
                    s = it.idx[t];
                    if (fp_mem[t][s] == '0 || fp_mem[t][s] == it.fp)
                    begin
                        r.status = (fp_mem[t][s] == '0) ? STAT_NEW : STAT_UPDATED;
                        fp_mem[t][s] = it.fp;
                        val_mem[t][s] = it.value;
                        r.hit_table = t[HTAB_W-1:0];
                        r.hit_slot = s;
                        done = 1;
                    end
                end
                if (!done && n_active < TABLES_DEF)
                begin
                    t = n_active;
                    s = it.idx[t];
                    n_active++;
                    fp_mem[t][s] = it.fp;
                    val_mem[t][s] = it.value;
                    r.status = STAT_NEW;
                    r.hit_table = t[HTAB_W-1:0];
                    r.hit_slot = s;
                end
            end
        end
        else
        begin
            r.status = (it.cmd == CMD_LOOKUP) ? STAT_MISS : STAT_REMOVE_MISS;
            if (it.fp != '0)
            begin
                for (t = 0; t < n_active && !done; t++)
                begin
                    s = it.idx[t];
                    if (fp_mem[t][s] == it.fp)
                    begin
                        if (it.cmd == CMD_LOOKUP)
                        begin
                            r.status = STAT_HIT;
                            r.read_value = val_mem[t][s];
                        end
                        else
                        begin
                            r.status = STAT_REMOVED;
                            fp_mem[t][s] = '0;
                        end
                        r.hit_table = t[HTAB_W-1:0];
                        r.hit_slot = s;
                        done = 1;
                    end
                end
            end
        end
        r.tables_active = n_active[TACT_W-1:0];
        return r;
    endfunction

    function automatic cmd_item_t mk(logic [CMD_W-1:0] cmd, logic [FP_W-1:0] fp,
                                     logic [IDX_W-1:0] i0, logic [IDX_W-1:0] i1,
                                     logic [IDX_W-1:0] i2, logic [IDX_W-1:0] i3,
                                     logic [EVAL_W-1:0] value);
        cmd_item_t it;
        it.pause = 0;
        it.cmd = cmd;
        it.fp = fp;
        it.idx = {i3, i2, i1, i0};
        it.value = value;
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                result_q.push_back(run_table_op(cur_item));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (cmd_q.size() != 0 && !(cmd_q[0].pause && result_q.size() != 0)
                    && (calm || $urandom_range(99) >= 8))
                begin
                    cur_item = cmd_q.pop_front();
                    s_tdata  <= {cur_item.value, cur_item.idx, cur_item.fp};
                    s_tuser  <= cur_item.cmd;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result beat with no command pending");
                    fail_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (m_tuser != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        fail_cnt++;
                    end
                    if (m_tdata[31:0] != want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value,
                               m_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[33:32] != want.hit_table)
                    begin
                        $error("hit_table: expected %0d, got %0d", want.hit_table,
                               m_tdata[33:32]);
                        fail_cnt++;
                    end
                    if (m_tdata[43:34] != want.hit_slot)
                    begin
                        $error("hit_slot: expected %0d, got %0d", want.hit_slot,
                               m_tdata[43:34]);
                        fail_cnt++;
                    end
                    if (m_tdata[46:44] != want.tables_active)
                    begin
                        $error("tables_active: expected %0d, got %0d", want.tables_active,
                               m_tdata[46:44]);
                        fail_cnt++;
                    end
                end
            end
            m_tready <= calm || $urandom_range(99) >= 8;
        end
    end

    initial
    begin
        cmd_item_t it;
        int        k;
        int        r;
        for (int t = 0; t < TABLES_DEF; t++)
            for (int j = 0; j < NSLOT; j++)
            begin
                fp_mem[t][j] = '0;
                val_mem[t][j] = '0;
            end
        n_active = 1;

        // empty table, zero fingerprint, activation of every subtable, full table
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h1, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_REMOVE, 32'h1, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INSERT, 32'h0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h0, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_REMOVE, 32'h0, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INSERT, 32'h1, 0, 0, 0, 0, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(CMD_INSERT, 32'h1, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INSERT, 32'h2, 0, 1023, 0, 0, 32'h5555_5555));
        cmd_q.push_back(mk(CMD_INSERT, 32'h3, 0, 1023, 1023, 0, 32'hAAAA_AAAA));
        cmd_q.push_back(mk(CMD_INSERT, 32'hFFFF_FFFF, 0, 1023, 1023, 1023, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(CMD_INSERT, 32'h8000_0000, 0, 1023, 1023, 1023, 32'h1234_5678));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h1, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'hFFFF_FFFF, 0, 1023, 1023, 1023, 32'h0));
        cmd_q.push_back(mk(CMD_REMOVE, 32'h2, 0, 1023, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h2, 0, 1023, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_INSERT, 32'h8000_0000, 0, 1023, 1023, 1023, 32'h8765_4321));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h8000_0000, 0, 1023, 1023, 1023, 32'h0));
        cmd_q.push_back(mk(CMD_INSERT, 32'h5A5A_5A5A, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h5A5A_5A5A, 1023, 1023, 1023, 1023, 32'h0));
        it = mk(CMD_CLEAR, 32'h0, 0, 0, 0, 0, 32'h0);
        it.pause = 1;
        cmd_q.push_back(it);
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h1, 0, 0, 0, 0, 32'h0));
        cmd_q.push_back(mk(CMD_LOOKUP, 32'h1234_5678, 10'h2AA, 10'h155, 10'h2AA, 10'h155,
                           32'h0));

        // key pool: most keys crowd a few slots so subtables fill and collide
        for (int p = 0; p < NPOOL; p++)
        begin
            pool_fp[p] = $urandom;
            if (pool_fp[p] == '0)
                pool_fp[p] = 32'h1;
            for (int t = 0; t < IDX_NUM; t++)
                pool_idx[p][t] = ($urandom_range(99) < 70) ? IDX_W'($urandom_range(3))
                                                           : IDX_W'($urandom_range(1023));
        end

        for (int n = 0; n < 450; n++)
        begin
            k = $urandom_range(NPOOL - 1);
            r = $urandom_range(99);
            it.pause = (n == 200);
            it.fp = pool_fp[k];
            it.idx = pool_idx[k];
            it.value = $urandom;
            if (r < 45)
                it.cmd = CMD_INSERT;
            else if (r < 72)
                it.cmd = CMD_LOOKUP;
            else if (r < 88)
                it.cmd = CMD_REMOVE;
            else if (r < 91)
                it.cmd = CMD_CLEAR;
            else
            begin
                // noise: stray fingerprints, zero fingerprint, scattered slots
                it.cmd = CMD_W'($urandom_range(2));
                r = $urandom_range(3);
                if (r == 0)
                    it.fp = '0;
                else if (r == 1)
                    it.fp = $urandom;
                for (int t = 0; t < IDX_NUM; t++)
                    it.idx[t] = IDX_W'($urandom_range(1023));
            end
            cmd_q.push_back(it);
        end
        total_items = cmd_q.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_cnt == total_items);
        wait (result_q.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
